>>> rtl/fdn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDN reverb package
// Shared constants, types and helper functions for the eight-line feedback
// delay network reverb core.
// ----------------------------------------------------------------------------
package fdn_pkg;

    // Network shape.
    localparam int LINES      = 8;
    localparam int LINE_DEPTH = 4096;
    localparam int LINE_W     = $clog2(LINES);
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int MEM_AW     = LINE_W + ADDR_W;
    localparam int MEM_DEPTH  = LINES << ADDR_W;
    localparam int MIN_DELAY  = 8;

    // Number formats.
    localparam int SAMPLE_W = 16;
    localparam int STORE_W  = 24;
    localparam int X_W      = 25;
    localparam int WORD_W   = 32;
    localparam int GAIN_W   = 18;
    localparam int PROD_W   = WORD_W + GAIN_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_W   = 15;
    localparam int RND_W    = ACC_W - FRAC_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int TDATA_W    = 2 * SAMPLE_W;

    typedef logic signed [GAIN_W-1:0]   t_gain;
    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic signed [STORE_W-1:0]  t_store;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [RND_W-1:0]    t_rnd;

    localparam t_gain UNITY = t_gain'(32768);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAINS_LO  = 3'd0,
        REG_GAINS_HI  = 3'd1,
        REG_DELAYS_LO = 3'd2,
        REG_DELAYS_HI = 3'd3,
        REG_DAMPING   = 3'd4,
        REG_IN_GAIN   = 3'd5,
        REG_WET_DRY   = 3'd6,
        REG_WIDTH     = 3'd7
    } t_reg_idx;

    // Clipped configuration seen by the sequencer.
    typedef struct packed {
        t_gain             damp;
        t_gain             one_m_damp;
        t_gain             in_gain;
        t_gain             wet;
        t_gain             dry;
        t_gain             width;
        t_gain             line_gain;
        logic [ADDR_W-1:0] line_delay;
    } t_cfg;

    // One operation for the shared multiply-accumulate unit.
    typedef struct packed {
        logic  en;
        logic  clr;
        t_word a;
        t_gain b;
    } t_mac_ctl;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_INJ, ST_INJR,
        ST_RD, ST_M1, ST_M2, ST_LP, ST_M3, ST_X,
        ST_OFS, ST_WR, ST_MONO,
        ST_W1, ST_W2, ST_W3,
        ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_OUT
    } t_state;

    localparam t_rnd STORE_HI  = t_rnd'((1 << (STORE_W - 1)) - 1);
    localparam t_rnd STORE_LO  = t_rnd'(-(1 << (STORE_W - 1)));
    localparam t_rnd SAMPLE_HI = t_rnd'((1 << (SAMPLE_W - 1)) - 1);
    localparam t_rnd SAMPLE_LO = t_rnd'(-(1 << (SAMPLE_W - 1)));

    // A gain field above unity counts as unity.
    function automatic t_gain gain_clip(input logic [15:0] g);
        t_gain res;
        res = (g > 16'd32768) ? UNITY : $signed({2'b00, g});
        return res;
    endfunction

    // Saturate a rounded value to the 24-bit store format.
    function automatic t_store sat_store(input t_rnd v);
        t_rnd res;
        res = (v > STORE_HI) ? STORE_HI : ((v < STORE_LO) ? STORE_LO : v);
        return res[STORE_W-1:0];
    endfunction

    // Saturate a rounded value to a 16-bit sample.
    function automatic t_sample sat_sample(input t_rnd v);
        t_rnd res;
        res = (v > SAMPLE_HI) ? SAMPLE_HI : ((v < SAMPLE_LO) ? SAMPLE_LO : v);
        return res[SAMPLE_W-1:0];
    endfunction

endpackage

>>> rtl/fdn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module fdn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fdn_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDN shared multiply-accumulate unit
// One signed 32 x 18 multiplier feeding an accumulator, with a Q1.15
// round-to-nearest view of the accumulator.
// ----------------------------------------------------------------------------
module fdn_mac (
    input  logic              i_clk,
    input  fdn_pkg::t_mac_ctl i_ctl,
    output fdn_pkg::t_rnd     o_rnd
);
    import fdn_pkg::*;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_rounded;
    logic signed [ACC_W-1:0]  r_acc;

    assign w_prod     = i_ctl.a * i_ctl.b;
    assign w_prod_ext = ACC_W'(w_prod);

    // Either start a new sum or add to the running one.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= i_ctl.clr ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    // Divide by 32768, rounding half toward plus infinity.
    assign w_rounded = r_acc + ACC_W'(1 << (FRAC_W - 1));
    assign o_rnd     = w_rounded[ACC_W-1:FRAC_W];

endmodule

>>> rtl/fdn_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDN configuration registers
// Holds the eight configuration registers, clips the gains to unity and
// picks out the gain and clamped delay of the line being worked on.
// ----------------------------------------------------------------------------
module fdn_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fdn_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fdn_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [fdn_pkg::LINE_W-1:0]       i_line,
    output fdn_pkg::t_cfg                    o_cfg
);
    import fdn_pkg::*;

    localparam logic [16:0] MAX_DELAY = 17'(LINE_DEPTH - 1);
    localparam logic [16:0] LOW_DELAY = 17'(MIN_DELAY);

    logic [63:0] r_gains_lo;
    logic [63:0] r_gains_hi;
    logic [63:0] r_delays_lo;
    logic [63:0] r_delays_hi;
    logic [15:0] r_damp;
    logic [15:0] r_in_gain;
    logic [31:0] r_wet_dry;
    logic [15:0] r_width;

    logic [63:0] w_gain_word;
    logic [63:0] w_delay_word;
    logic [15:0] w_gain16;
    logic [16:0] w_delay17;
    logic [16:0] w_delay_clamped;
    t_gain       w_damp;

    // Register writes; every index of the port maps to a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains_lo  <= '0;
            r_gains_hi  <= '0;
            r_delays_lo <= '0;
            r_delays_hi <= '0;
            r_damp      <= 16'd24412;
            r_in_gain   <= 16'd8192;
            r_wet_dry   <= 32'd22938;
            r_width     <= 16'd32768;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_GAINS_LO:  r_gains_lo  <= i_cfg_data;
                REG_GAINS_HI:  r_gains_hi  <= i_cfg_data;
                REG_DELAYS_LO: r_delays_lo <= i_cfg_data;
                REG_DELAYS_HI: r_delays_hi <= i_cfg_data;
                REG_DAMPING:   r_damp      <= i_cfg_data[15:0];
                REG_IN_GAIN:   r_in_gain   <= i_cfg_data[15:0];
                REG_WET_DRY:   r_wet_dry   <= i_cfg_data[31:0];
                REG_WIDTH:     r_width     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Per-line fields: lines 0 to 3 sit in the low word, 4 to 7 in the high.
    assign w_gain_word  = i_line[LINE_W-1] ? r_gains_hi : r_gains_lo;
    assign w_delay_word = i_line[LINE_W-1] ? r_delays_hi : r_delays_lo;
    assign w_gain16     = 16'(w_gain_word >> {i_line[1:0], 4'b0000});
    assign w_delay17    = {1'b0, 16'(w_delay_word >> {i_line[1:0], 4'b0000})};

    // Clamp the delay to the usable span of a line.
    assign w_delay_clamped = (w_delay17 < LOW_DELAY) ? LOW_DELAY :
                             ((w_delay17 > MAX_DELAY) ? MAX_DELAY : w_delay17);

    assign w_damp = gain_clip(r_damp);

    assign o_cfg.damp       = w_damp;
    assign o_cfg.one_m_damp = UNITY - w_damp;
    assign o_cfg.in_gain    = gain_clip(r_in_gain);
    assign o_cfg.wet        = gain_clip(r_wet_dry[31:16]);
    assign o_cfg.dry        = gain_clip(r_wet_dry[15:0]);
    assign o_cfg.width      = gain_clip(r_width);
    assign o_cfg.line_gain  = gain_clip(w_gain16);
    assign o_cfg.line_delay = w_delay_clamped[ADDR_W-1:0];

endmodule

>>> rtl/fdn_reverb_frame_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDN reverb frame step core
// Eight-line feedback delay network reverb with Householder mixing, one
// stereo frame per item, built around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one stereo frame per item (left and right
//   samples); the output stream returns one processed stereo frame per item.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the core is idle; a write takes effect at the clock edge it is seen.
//   A new input item is accepted only after the result of the previous one
//   has been loaded into the output register. The pace comes from the
//   single multiplier, which performs 31 multiplies per frame, and from
//   the six-step sequence per line (tap read, two lowpass products, round,
//   gain product, round) followed by a write-back pass over the eight
//   lines through the one delay memory port.
//   s_axis_tready is high only while the sequencer is idle.
//   Reset clears the sequencer, the write pointer and the lowpass states.
//   The delay memory is not swept: a fill flag and the write pointer tell
//   which taps were written since reset, and unwritten taps read as zero.
//   A finished result waits in the output register while the next item is
//   processed; if the receiver still stalls when that item is done, the
//   core holds its result until the output register frees up.
// ----------------------------------------------------------------------------
module fdn_reverb_frame_step_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream: tdata = {right_in, left_in} (left_in in bits 15:0).
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fdn_pkg::TDATA_W-1:0]     s_axis_tdata,
    // Output stream: tdata = {right_out, left_out} (left_out in bits 15:0).
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fdn_pkg::TDATA_W-1:0]     m_axis_tdata,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [fdn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fdn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fdn_pkg::*;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_DEPTH - 1);

    t_state            r_state, n_state;
    logic [LINE_W-1:0] r_line, n_line;
    logic [ADDR_W-1:0] r_wp;
    logic              r_wrapped;
    logic              r_tap_ok;

    t_sample r_in_l, r_in_r;
    t_word   r_inject;
    t_store  r_lp [LINES];
    logic signed [X_W-1:0] r_x [LINES];
    t_word   r_sum, r_offset, r_sl, r_sr, r_mono, r_revl, r_revr;
    t_sample r_res_l, r_res_r, r_out_l, r_out_r;
    logic    r_out_valid;

    t_cfg              w_cfg;
    t_mac_ctl          w_mac;
    t_rnd              w_rnd;
    logic [ADDR_W-1:0] w_rp;
    logic              w_tap_ok;
    logic [STORE_W-1:0] w_rdata;
    t_word             w_tap;
    logic signed [SAMPLE_W:0] w_pair;
    t_word             w_y;
    t_word             w_wsum;
    t_store            w_wdata;
    logic              w_we;
    logic              w_out_load;

    fdn_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_line     (r_line),
        .o_cfg      (w_cfg)
    );

    fdn_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac),
        .o_rnd (w_rnd)
    );

    fdn_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({r_line, r_wp}),
        .i_wdata (w_wdata),
        .i_raddr ({r_line, w_rp}),
        .o_rdata (w_rdata)
    );

    // Tap address, delay samples behind the write pointer, modulo the depth.
    always_comb begin
        if (r_wp >= w_cfg.line_delay) begin
            w_rp = r_wp - w_cfg.line_delay;
        end else begin
            w_rp = ADDR_W'({1'b0, r_wp} + (ADDR_W + 1)'(LINE_DEPTH)
                           - {1'b0, w_cfg.line_delay});
        end
    end

    // A tap was written since reset once the pointer has wrapped or passed it.
    assign w_tap_ok = r_wrapped || (w_rp < r_wp);
    assign w_tap    = r_tap_ok ? WORD_W'($signed(w_rdata)) : '0;

    // Write-back value: line value minus the Householder offset plus input.
    assign w_pair  = (SAMPLE_W + 1)'(r_in_l) + (SAMPLE_W + 1)'(r_in_r);
    assign w_y     = WORD_W'(r_x[r_line]) - r_offset;
    assign w_wsum  = w_y + r_inject;
    assign w_wdata = sat_store(RND_W'(w_wsum));
    assign w_we    = (r_state == ST_WR);

    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_INJ;
            ST_INJ:  n_state = ST_INJR;
            ST_INJR: n_state = ST_RD;
            ST_RD:   n_state = ST_M1;
            ST_M1:   n_state = ST_M2;
            ST_M2:   n_state = ST_LP;
            ST_LP:   n_state = ST_M3;
            ST_M3:   n_state = ST_X;
            ST_X:    n_state = (r_line == LAST_LINE) ? ST_OFS : ST_RD;
            ST_OFS:  n_state = ST_WR;
            ST_WR:   n_state = (r_line == LAST_LINE) ? ST_MONO : ST_WR;
            ST_MONO: n_state = ST_W1;
            ST_W1:   n_state = ST_W2;
            ST_W2:   n_state = ST_W3;
            ST_W3:   n_state = ST_O1;
            ST_O1:   n_state = ST_O2;
            ST_O2:   n_state = ST_O3;
            ST_O3:   n_state = ST_O4;
            ST_O4:   n_state = ST_O5;
            ST_O5:   n_state = ST_OUT;
            ST_OUT:  if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Line counter steps after each line of the read pass and write pass.
    always_comb begin
        n_line = r_line;
        if (r_state == ST_X || r_state == ST_WR) begin
            n_line = (r_line == LAST_LINE) ? '0 : r_line + 1'b1;
        end
    end

    // Operation issued to the shared multiply-accumulate unit.
    always_comb begin
        w_mac.en  = 1'b1;
        w_mac.clr = 1'b1;
        w_mac.a   = '0;
        w_mac.b   = '0;
        case (r_state)
            ST_INJ: begin
                w_mac.a = WORD_W'(w_pair);
                w_mac.b = w_cfg.in_gain;
            end
            ST_M1: begin
                w_mac.a = w_tap;
                w_mac.b = w_cfg.damp;
            end
            ST_M2: begin
                w_mac.clr = 1'b0;
                w_mac.a   = WORD_W'(r_lp[r_line]);
                w_mac.b   = w_cfg.one_m_damp;
            end
            ST_M3: begin
                w_mac.a = WORD_W'(r_lp[r_line]);
                w_mac.b = w_cfg.line_gain;
            end
            ST_W1: begin
                w_mac.a = r_sl - r_mono;
                w_mac.b = w_cfg.width;
            end
            ST_W2: begin
                w_mac.a = r_sr - r_mono;
                w_mac.b = w_cfg.width;
            end
            ST_O1: begin
                w_mac.a = r_revl;
                w_mac.b = w_cfg.wet;
            end
            ST_O2: begin
                w_mac.clr = 1'b0;
                w_mac.a   = WORD_W'(r_in_l);
                w_mac.b   = w_cfg.dry;
            end
            ST_O3: begin
                w_mac.a = r_revr;
                w_mac.b = w_cfg.wet;
            end
            ST_O4: begin
                w_mac.clr = 1'b0;
                w_mac.a   = WORD_W'(r_in_r);
                w_mac.b   = w_cfg.dry;
            end
            default: w_mac.en = 1'b0;
        endcase
    end

    // Sequencer control state, write pointer and lowpass states.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_line    <= '0;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                r_lp[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_line  <= n_line;
            if (r_state == ST_LP) begin
                r_lp[r_line] <= sat_store(w_rnd);
            end
            // The single write pointer, shared by all lines, advances once per frame.
            if (r_state == ST_MONO) begin
                r_wp <= (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
                if (r_wp == LAST_ADDR) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    // Datapath registers loaded at the steps of the sequence.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_in_l <= s_axis_tdata[SAMPLE_W-1:0];
                r_in_r <= s_axis_tdata[TDATA_W-1:SAMPLE_W];
                r_sum  <= '0;
                r_sl   <= '0;
                r_sr   <= '0;
            end
            ST_INJR: r_inject <= WORD_W'(w_rnd);
            ST_RD:   r_tap_ok <= w_tap_ok;
            ST_X: begin
                r_x[r_line] <= w_rnd[X_W-1:0];
                r_sum       <= r_sum + WORD_W'(w_rnd);
            end
            // Householder offset: 2/8 of the line sum, rounded.
            ST_OFS:  r_offset <= (r_sum + t_word'(2)) >>> 2;
            ST_WR: begin
                if (r_line[0]) begin
                    r_sr <= r_sr + w_y;
                end else begin
                    r_sl <= r_sl + w_y;
                end
            end
            ST_MONO: r_mono <= (r_sl + r_sr + t_word'(1)) >>> 1;
            ST_W2:   r_revl <= r_mono + WORD_W'(w_rnd);
            ST_W3:   r_revr <= r_mono + WORD_W'(w_rnd);
            ST_O3:   r_res_l <= sat_sample(w_rnd);
            ST_O5:   r_res_r <= sat_sample(w_rnd);
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_l};

endmodule
